// ===== src/grc_pkg.sv =====
package grc_pkg;

    localparam logic [1:0] CFG_LEFT_DZ   = 2'd0;
    localparam logic [1:0] CFG_RIGHT_DZ  = 2'd1;
    localparam logic [1:0] CFG_TRIG_TH   = 2'd2;
    localparam logic [1:0] CFG_BTN_MASK  = 2'd3;

    localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
    localparam logic [7:0]  TRIG_TH_RESET  = 8'd30;
    localparam logic [15:0] BTN_MASK_RESET = 16'd62463;

    localparam logic [7:0]  TRIG_FULL = 8'd255;
    localparam logic [15:0] LEVEL_MAX = 16'hFFFF;

    typedef struct packed {
        logic        conn;
        logic [15:0] pressed;
        logic [15:0] released;
        logic [63:0] sticks;
        logic [15:0] triggers;
    } job_t;

endpackage

// ===== src/gamepad_report_conditioner_unit.sv =====
// Conditions one controller report per item: packet de-duplication, masked
// button press/release edges, radial dead zone with unit direction per stick
// (Q1.15) and thresholded trigger levels (Q0.16). The front takes an item into
// a two-entry queue; in the back each stick has setup states (square, then sum)
// plus, outside its dead zone, a bit-serial search (15 bits, two chained
// multiplies per bit), then a restoring divider pass works on both triggers
// side by side with a shared divisor, followed by a hand-off state.
// The stick search unit sets the rate. in_stall rises only when the queue is
// full; configuration writes are registered and should be made while idle.
module gamepad_report_conditioner_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                connected,
    input  logic [31:0]         packet_number,
    input  logic [15:0]         buttons,
    input  logic signed [15:0]  left_stick_x,
    input  logic signed [15:0]  left_stick_y,
    input  logic signed [15:0]  right_stick_x,
    input  logic signed [15:0]  right_stick_y,
    input  logic [7:0]          left_trigger,
    input  logic [7:0]          right_trigger,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                is_connected,
    output logic [15:0]         pressed_mask,
    output logic [15:0]         released_mask,
    output logic signed [15:0]  left_dir_x,
    output logic signed [15:0]  left_dir_y,
    output logic signed [15:0]  right_dir_x,
    output logic signed [15:0]  right_dir_y,
    output logic [15:0]         left_trigger_level,
    output logic [15:0]         right_trigger_level,
    input  logic                cfg_write_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import grc_pkg::*;

    logic [14:0] left_dz_reg, right_dz_reg;
    logic [7:0]  th_reg;
    logic [15:0] mask_reg;
    logic        accept, q_full, q_valid, q_pop;
    job_t        push_job, pop_job;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dz_reg  <= LEFT_DZ_RESET;
            right_dz_reg <= RIGHT_DZ_RESET;
            th_reg       <= TRIG_TH_RESET;
            mask_reg     <= BTN_MASK_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_LEFT_DZ:  left_dz_reg  <= cfg_data[14:0];
                CFG_RIGHT_DZ: right_dz_reg <= cfg_data[14:0];
                CFG_TRIG_TH:  th_reg       <= cfg_data[7:0];
                CFG_BTN_MASK: mask_reg     <= cfg_data;
                default:      mask_reg     <= mask_reg;
            endcase
        end
    end

    grc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .connected     (connected),
        .packet_number (packet_number),
        .buttons       (buttons),
        .left_stick_x  (left_stick_x),
        .left_stick_y  (left_stick_y),
        .right_stick_x (right_stick_x),
        .right_stick_y (right_stick_y),
        .left_trigger  (left_trigger),
        .right_trigger (right_trigger),
        .button_mask   (mask_reg),
        .job           (push_job)
    );

    grc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_job   (pop_job)
    );

    grc_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .job_valid           (q_valid),
        .job                 (pop_job),
        .job_pop             (q_pop),
        .left_dz             (left_dz_reg),
        .right_dz            (right_dz_reg),
        .threshold           (th_reg),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .is_connected        (is_connected),
        .pressed_mask        (pressed_mask),
        .released_mask       (released_mask),
        .left_dir_x          (left_dir_x),
        .left_dir_y          (left_dir_y),
        .right_dir_x         (right_dir_x),
        .right_dir_y         (right_dir_y),
        .left_trigger_level  (left_trigger_level),
        .right_trigger_level (right_trigger_level)
    );

    a_disc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_connected) |-> (pressed_mask == 16'd0 && released_mask == 16'd0
        && left_dir_x == 16'sd0 && right_dir_y == 16'sd0 && left_trigger_level == 16'd0))
        else $error("disconnected item with nonzero result");

    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pressed_mask & released_mask) == 16'd0))
        else $error("button both pressed and released");

    a_dir_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_dir_x != 16'sh8000 && left_dir_y != 16'sh8000
        && right_dir_x != 16'sh8000 && right_dir_y != 16'sh8000))
        else $error("direction out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

// ===== src/grc_front.sv =====
module grc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               connected,
    input  logic [31:0]        packet_number,
    input  logic [15:0]        buttons,
    input  logic [15:0]        left_stick_x,
    input  logic [15:0]        left_stick_y,
    input  logic [15:0]        right_stick_x,
    input  logic [15:0]        right_stick_y,
    input  logic [7:0]         left_trigger,
    input  logic [7:0]         right_trigger,
    input  logic [15:0]        button_mask,
    output grc_pkg::job_t      job
);
    import grc_pkg::*;

    logic        link_up_reg, link_up_next;
    logic [31:0] packet_reg, packet_next;
    logic [15:0] prev_btn_reg, prev_btn_next;
    logic [15:0] cur_btn_reg, cur_btn_next;
    logic [63:0] sticks_reg, sticks_next;
    logic [15:0] trig_reg, trig_next;
    logic        fresh;

    always_comb
    begin
        link_up_next  = link_up_reg;
        packet_next   = packet_reg;
        prev_btn_next = prev_btn_reg;
        cur_btn_next  = cur_btn_reg;
        sticks_next   = sticks_reg;
        trig_next     = trig_reg;
        fresh         = 1'b0;
        if (!connected)
        begin
            link_up_next  = 1'b0;
            packet_next   = 32'd0;
            prev_btn_next = 16'd0;
            cur_btn_next  = 16'd0;
            sticks_next   = 64'd0;
            trig_next     = 16'd0;
        end
        else
        begin
            link_up_next = 1'b1;
            if (packet_number != packet_reg)
            begin
                fresh         = 1'b1;
                packet_next   = packet_number;
                prev_btn_next = cur_btn_reg;
                cur_btn_next  = buttons;
                sticks_next   = {right_stick_y, right_stick_x, left_stick_y, left_stick_x};
                trig_next     = {right_trigger, left_trigger};
            end
        end
    end

    always_comb
    begin
        job.conn     = link_up_next;
        job.pressed  = fresh ? (~prev_btn_next & cur_btn_next & button_mask) : 16'd0;
        job.released = fresh ? (prev_btn_next & ~cur_btn_next & button_mask) : 16'd0;
        job.sticks   = sticks_next;
        job.triggers = trig_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg  <= 1'b0;
            packet_reg   <= 32'd0;
            prev_btn_reg <= 16'd0;
            cur_btn_reg  <= 16'd0;
            sticks_reg   <= 64'd0;
            trig_reg     <= 16'd0;
        end
        else if (accept)
        begin
            link_up_reg  <= link_up_next;
            packet_reg   <= packet_next;
            prev_btn_reg <= prev_btn_next;
            cur_btn_reg  <= cur_btn_next;
            sticks_reg   <= sticks_next;
            trig_reg     <= trig_next;
        end
    end

endmodule

// ===== src/grc_queue.sv =====
module grc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  grc_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output grc_pkg::job_t  pop_job
);
    import grc_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== src/grc_back.sv =====
module grc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  grc_pkg::job_t       job,
    output logic                job_pop,
    input  logic [14:0]         left_dz,
    input  logic [14:0]         right_dz,
    input  logic [7:0]          threshold,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                is_connected,
    output logic [15:0]         pressed_mask,
    output logic [15:0]         released_mask,
    output logic signed [15:0]  left_dir_x,
    output logic signed [15:0]  left_dir_y,
    output logic signed [15:0]  right_dir_x,
    output logic signed [15:0]  right_dir_y,
    output logic [15:0]         left_trigger_level,
    output logic [15:0]         right_trigger_level
);
    import grc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_TT    = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_TINIT = 3'd5;
    localparam logic [2:0] ST_TRIG  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]  state_reg;
    job_t        job_reg;
    logic        sel_reg;
    logic        nx_reg, ny_reg;
    logic [31:0] axsq_reg, aysq_reg;
    logic [29:0] dzsq_reg;
    logic [31:0] s_reg;
    logic [14:0] qx_reg, qy_reg;
    logic [3:0]  bit_reg;
    logic [31:0] ttx_reg, tty_reg;
    logic [15:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic [25:0] rem_l_reg, rem_r_reg;
    logic [16:0] q_l_reg, q_r_reg;
    logic        tz_l_reg, tz_r_reg;
    logic [8:0]  div_reg;
    logic [4:0]  step_reg;
    logic        out_valid_reg;

    logic [15:0] sx, sy, ax, ay;
    logic [14:0] dz, bmask, qx_try, qy_try, qx_new, qy_new;
    logic [15:0] tx, ty, dir_x, dir_y;
    logic [31:0] s_sum;
    logic [63:0] px, py, lim_x, lim_y;
    logic [25:0] dshift;
    logic [7:0]  d8, diff_l, diff_r;
    logic [16:0] q_l_new, q_r_new;
    logic        out_free;

    assign sx     = sel_reg ? job_reg.sticks[47:32] : job_reg.sticks[15:0];
    assign sy     = sel_reg ? job_reg.sticks[63:48] : job_reg.sticks[31:16];
    assign ax     = sx[15] ? (~sx + 16'd1) : sx;
    assign ay     = sy[15] ? (~sy + 16'd1) : sy;
    assign dz     = sel_reg ? right_dz : left_dz;
    assign s_sum  = axsq_reg + aysq_reg;
    assign bmask  = 15'd1 << bit_reg;
    assign qx_try = qx_reg | bmask;
    assign qy_try = qy_reg | bmask;
    assign tx     = {qx_try, 1'b0} - 16'd1;
    assign ty     = {qy_try, 1'b0} - 16'd1;
    assign px     = 64'(ttx_reg) * 64'(s_reg);
    assign py     = 64'(tty_reg) * 64'(s_reg);
    assign lim_x  = {axsq_reg, 32'd0};
    assign lim_y  = {aysq_reg, 32'd0};
    assign qx_new = (px <= lim_x) ? qx_try : qx_reg;
    assign qy_new = (py <= lim_y) ? qy_try : qy_reg;
    assign dir_x  = nx_reg ? (16'd0 - {1'b0, qx_new}) : {1'b0, qx_new};
    assign dir_y  = ny_reg ? (16'd0 - {1'b0, qy_new}) : {1'b0, qy_new};
    assign d8     = TRIG_FULL - threshold;
    assign diff_l = job_reg.triggers[7:0] - threshold;
    assign diff_r = job_reg.triggers[15:8] - threshold;
    assign dshift = 26'(div_reg) << step_reg;
    assign q_l_new = q_l_reg | ((rem_l_reg >= dshift) ? (17'd1 << step_reg) : 17'd0);
    assign q_r_new = q_r_reg | ((rem_r_reg >= dshift) ? (17'd1 << step_reg) : 17'd0);
    assign out_free = !out_valid_reg || !out_stall;
    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg <= job;
                end
            end
            ST_SQ:
            begin
                axsq_reg <= 32'(ax) * 32'(ax);
                aysq_reg <= 32'(ay) * 32'(ay);
                dzsq_reg <= 30'(dz) * 30'(dz);
                nx_reg   <= sx[15];
                ny_reg   <= sy[15];
            end
            ST_SUM:
            begin
                s_reg   <= s_sum;
                qx_reg  <= 15'd0;
                qy_reg  <= 15'd0;
                bit_reg <= 4'd14;
                if (s_sum <= 32'(dzsq_reg))
                begin
                    if (sel_reg)
                    begin
                        rx_reg <= 16'd0;
                        ry_reg <= 16'd0;
                    end
                    else
                    begin
                        lx_reg <= 16'd0;
                        ly_reg <= 16'd0;
                    end
                end
            end
            ST_TT:
            begin
                ttx_reg <= 32'(tx) * 32'(tx);
                tty_reg <= 32'(ty) * 32'(ty);
            end
            ST_CMP:
            begin
                qx_reg  <= qx_new;
                qy_reg  <= qy_new;
                bit_reg <= bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    if (sel_reg)
                    begin
                        rx_reg <= dir_x;
                        ry_reg <= dir_y;
                    end
                    else
                    begin
                        lx_reg <= dir_x;
                        ly_reg <= dir_y;
                    end
                end
            end
            ST_TINIT:
            begin
                div_reg   <= {d8, 1'b0};
                rem_l_reg <= 26'({diff_l, 17'd0}) + 26'(d8);
                rem_r_reg <= 26'({diff_r, 17'd0}) + 26'(d8);
                tz_l_reg  <= (job_reg.triggers[7:0] <= threshold);
                tz_r_reg  <= (job_reg.triggers[15:8] <= threshold);
                q_l_reg   <= 17'd0;
                q_r_reg   <= 17'd0;
                step_reg  <= 5'd16;
            end
            ST_TRIG:
            begin
                q_l_reg  <= q_l_new;
                q_r_reg  <= q_r_new;
                if (rem_l_reg >= dshift)
                begin
                    rem_l_reg <= rem_l_reg - dshift;
                end
                if (rem_r_reg >= dshift)
                begin
                    rem_r_reg <= rem_r_reg - dshift;
                end
                step_reg <= step_reg - 5'd1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    is_connected  <= job_reg.conn;
                    pressed_mask  <= job_reg.pressed;
                    released_mask <= job_reg.released;
                    left_dir_x    <= lx_reg;
                    left_dir_y    <= ly_reg;
                    right_dir_x   <= rx_reg;
                    right_dir_y   <= ry_reg;
                    left_trigger_level  <= tz_l_reg ? 16'd0 :
                                           (q_l_reg[16] ? LEVEL_MAX : q_l_reg[15:0]);
                    right_trigger_level <= tz_r_reg ? 16'd0 :
                                           (q_r_reg[16] ? LEVEL_MAX : q_r_reg[15:0]);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        sel_reg   <= 1'b0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (s_sum <= 32'(dzsq_reg))
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= sel_reg ? ST_TINIT : ST_SQ;
                    end
                    else
                    begin
                        state_reg <= ST_TT;
                    end
                end
                ST_TT:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (bit_reg == 4'd0)
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= sel_reg ? ST_TINIT : ST_SQ;
                    end
                    else
                    begin
                        state_reg <= ST_TT;
                    end
                end
                ST_TINIT:
                begin
                    state_reg <= ST_TRIG;
                end
                ST_TRIG:
                begin
                    if (step_reg == 5'd0)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
